### rtl/csa_pkg.sv
// Shared types and default sizes for the count sketch accumulator.
// No dependencies.
`default_nettype none

package csa_pkg;

  localparam int BINS_DEF       = 1024;
  localparam int SAMPLE_W_DEF   = 32;
  localparam int SUM_W_DEF      = 48;
  localparam int LABEL_W        = 10;

  typedef enum logic {
    REQ_ACC  = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef struct packed {
    logic valid;
    req_e req;
    logic in_range;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/csa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire  logic                          clk_i,
  input  wire  logic                          we_i,
  input  wire  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  wire  logic [WIDTH-1:0]              wdata_i,
  input  wire  logic                          re_i,
  input  wire  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic       [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/csa_accum.sv
// Bin update: saturating add of a signed sample into a bin, or read and clear.
// Depends on csa_pkg.
`default_nettype none

module csa_accum #(
  parameter int SAMPLE_WIDTH = csa_pkg::SAMPLE_W_DEF,
  parameter int SUM_WIDTH    = csa_pkg::SUM_W_DEF
) (
  input  wire  csa_pkg::ctl_t                 ctl_i,
  input  wire  logic signed [SAMPLE_WIDTH:0]  addend_i,
  input  wire  logic signed [SUM_WIDTH-1:0]   cur_sum_i,
  input  wire  logic                          cur_mark_i,
  output logic                                wr_en_o,
  output logic        [SUM_WIDTH-1:0]         new_sum_o,
  output logic                                new_mark_o,
  output logic        [SUM_WIDTH-1:0]         out_sum_o,
  output logic                                out_mark_o
);

  import csa_pkg::*;

  localparam int EW = ((SUM_WIDTH > SAMPLE_WIDTH + 1) ? SUM_WIDTH : SAMPLE_WIDTH + 1) + 1;

  logic [EW-1:0]           exact;
  logic [EW-SUM_WIDTH:0]   top_bits;
  logic                    ovf;
  logic [SUM_WIDTH-1:0]    clamp;

  assign exact = {{(EW-SUM_WIDTH){cur_sum_i[SUM_WIDTH-1]}}, cur_sum_i}
               + {{(EW-SAMPLE_WIDTH-1){addend_i[SAMPLE_WIDTH]}}, addend_i};
  assign top_bits = exact[EW-1:SUM_WIDTH-1];
  assign ovf      = ~((&top_bits) | ~(|top_bits));
  assign clamp    = exact[EW-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                : {1'b0, {(SUM_WIDTH-1){1'b1}}};

  always_comb begin
    wr_en_o    = ctl_i.valid & ctl_i.in_range;
    out_sum_o  = ctl_i.in_range ? cur_sum_i : '0;
    out_mark_o = ctl_i.in_range & cur_mark_i;
    unique case (ctl_i.req)
      REQ_ACC: begin
        new_sum_o  = ovf ? clamp : exact[SUM_WIDTH-1:0];
        new_mark_o = cur_mark_i | ovf;
      end
      REQ_READ: begin
        new_sum_o  = '0;
        new_mark_o = 1'b0;
      end
      default: begin
        new_sum_o  = '0;
        new_mark_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/count_sketch_accumulator_core.sv
// Count sketch accumulator top level: bin table RAM, update stage, clear pass.
// Depends on csa_pkg, csa_ram, csa_accum.
//
// Usage:
//   Input beat: start high while busy is low takes one request: req_type_i
//   0 adds sample_value_i (negated unless keep_sign_i) into bin bin_label_i,
//   1 reads that bin, returns its sum and sticky saturation mark, and clears it.
//   Result beat: done_o high for one cycle with bin_index_o, bin_value_o and
//   bin_saturated_o; one per read, none per accumulate. Labels of BINS or more
//   are ignored on accumulate and read back as zero.
//   Results: a read passes the update stage register, then the result registers.
//   Throughput: one request per cycle while busy is low. The bin RAM is read
//   in the accept cycle and written back the next; a back-to-back hit on the
//   same bin is served from a forwarding register.
//   Reset: a clear pass writes zero to every bin, one per cycle, with busy
//   high; requests are taken once it is done.
//   The receiver cannot stall: results are presented once only.
`default_nettype none

module count_sketch_accumulator_core #(
  parameter int BINS         = csa_pkg::BINS_DEF,
  parameter int SAMPLE_WIDTH = csa_pkg::SAMPLE_W_DEF,
  parameter int SUM_WIDTH    = csa_pkg::SUM_W_DEF
) (
  input  wire  logic                            clk_i,
  input  wire  logic                            rst_ni,
  input  wire  logic                            start,
  output logic                                  busy,
  input  wire  logic                            req_type_i,
  input  wire  logic [csa_pkg::LABEL_W-1:0]     bin_label_i,
  input  wire  logic                            keep_sign_i,
  input  wire  logic signed [SAMPLE_WIDTH-1:0]  sample_value_i,
  output logic                                  done_o,
  output logic       [csa_pkg::LABEL_W-1:0]     bin_index_o,
  output logic signed [SUM_WIDTH-1:0]           bin_value_o,
  output logic                                  bin_saturated_o
);

  import csa_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int MW = SUM_WIDTH + 1;

  logic                      accept;
  logic                      clearing_q, clearing_d;
  logic [AW-1:0]             clr_cnt_q, clr_cnt_d;

  ctl_t                      ctl_d, s1_ctl_q;
  logic [LABEL_W-1:0]        s1_label_q;
  logic [AW-1:0]             s1_addr_q;
  logic signed [SAMPLE_WIDTH:0] sext, add_d, s1_add_q;

  logic                      fwd_vld_q;
  logic [AW-1:0]             fwd_addr_q;
  logic [MW-1:0]             fwd_data_q;

  logic [MW-1:0]             rdata;
  logic [MW-1:0]             oper;
  logic                      upd_we;
  logic [SUM_WIDTH-1:0]      new_sum, out_sum;
  logic                      new_mark, out_mark;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [MW-1:0]             ram_wdata;

  assign busy   = clearing_q;
  assign accept = start & ~busy;

  assign sext  = {sample_value_i[SAMPLE_WIDTH-1], sample_value_i};
  assign add_d = keep_sign_i ? sext : -sext;

  always_comb begin
    ctl_d.valid    = accept;
    ctl_d.req      = req_e'(req_type_i);
    ctl_d.in_range = (32'(bin_label_i) < 32'(BINS));
  end

  // clear pass after reset
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(BINS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  assign oper = (fwd_vld_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rdata;

  csa_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_accum (
    .ctl_i      (s1_ctl_q),
    .addend_i   (s1_add_q),
    .cur_sum_i  (oper[SUM_WIDTH-1:0]),
    .cur_mark_i (oper[SUM_WIDTH]),
    .wr_en_o    (upd_we),
    .new_sum_o  (new_sum),
    .new_mark_o (new_mark),
    .out_sum_o  (out_sum),
    .out_mark_o (out_mark)
  );

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_addr_q;
      ram_wdata = {new_mark, new_sum};
    end
  end

  csa_ram #(
    .WIDTH (MW),
    .DEPTH (BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (AW'(bin_label_i)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_ctl_q   <= '0;
      fwd_vld_q  <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_ctl_q   <= ctl_d;
      if (upd_we) begin
        fwd_vld_q <= 1'b1;
      end
      done_o     <= s1_ctl_q.valid && s1_ctl_q.req == REQ_READ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_label_q <= bin_label_i;
      s1_addr_q  <= AW'(bin_label_i);
      s1_add_q   <= add_d;
    end
    if (upd_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= {new_mark, new_sum};
    end
    bin_index_o     <= s1_label_q;
    bin_value_o     <= out_sum;
    bin_saturated_o <= out_mark;
  end

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_ctl_q.valid)
    else $error("update stage active during clear pass");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_ctl_q.valid)
    else $error("accepted beat lost before update stage");

  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s1_ctl_q.valid && s1_ctl_q.req == REQ_READ))
    else $error("result beat without a read");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(s1_ctl_q.in_range)) |-> (bin_value_o == '0 && !bin_saturated_o))
    else $error("out of range read returned non-zero");

  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_cnt_q) == AW'(BINS - 1))
    else $error("clear pass ended early");

endmodule

`default_nettype wire

### tb/csa_checker.sv
// Scoreboard for the count sketch accumulator: watches request and result beats,
// keeps its own bin table and saturation marks, and counts mismatches.
// Depends on csa_pkg.
module csa_checker #(
  parameter int BINS         = csa_pkg::BINS_DEF,
  parameter int SAMPLE_WIDTH = csa_pkg::SAMPLE_W_DEF,
  parameter int SUM_WIDTH    = csa_pkg::SUM_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              req_type_i,
  input  logic [csa_pkg::LABEL_W-1:0]       bin_label_i,
  input  logic                              keep_sign_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_value_i,
  input  logic                              done_o,
  input  logic [csa_pkg::LABEL_W-1:0]       bin_index_o,
  input  logic signed [SUM_WIDTH-1:0]       bin_value_o,
  input  logic                              bin_saturated_o,
  output int                                fail_count_o,
  output int                                pending_o
);

  import csa_pkg::*;

  localparam longint SUM_MAX = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic [LABEL_W-1:0]          idx;
    logic signed [SUM_WIDTH-1:0] val;
    logic                        sat;
  } read_beat_t;

  read_beat_t                  read_results_due[$];
  logic signed [SUM_WIDTH-1:0] bin_sums [BINS];
  logic                        bin_marks [BINS];
  int                          mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // accumulate or read-and-clear on the shadow table
  task automatic update_bins();
    longint     delta;
    longint     total;
    read_beat_t beat;
    if (req_type_i == REQ_READ) begin
      beat.idx = bin_label_i;
      if (bin_label_i < BINS) begin
        beat.val = bin_sums[bin_label_i];
        beat.sat = bin_marks[bin_label_i];
        bin_sums[bin_label_i]  = '0;
        bin_marks[bin_label_i] = 1'b0;
      end else begin
        beat.val = '0;
        beat.sat = 1'b0;
      end
      read_results_due.push_back(beat);
    end else if (bin_label_i < BINS) begin
      delta = longint'(sample_value_i);
      if (!keep_sign_i) delta = -delta;
      total = longint'(bin_sums[bin_label_i]) + delta;
      if (total > SUM_MAX) begin
        total = SUM_MAX;
        bin_marks[bin_label_i] = 1'b1;
      end else if (total < SUM_MIN) begin
        total = SUM_MIN;
        bin_marks[bin_label_i] = 1'b1;
      end
      bin_sums[bin_label_i] = total[SUM_WIDTH-1:0];
    end
  endtask

  task automatic compare_read_beat();
    read_beat_t exp_beat;
    if (read_results_due.size() == 0) begin
      $display("%0t: unexpected result beat: index %0d value %0d sat %0b", $time,
               bin_index_o, bin_value_o, bin_saturated_o);
      mismatches++;
    end else begin
      exp_beat = read_results_due.pop_front();
      if (bin_index_o !== exp_beat.idx) begin
        $display("%0t: bin_index expected %0d actual %0d", $time, exp_beat.idx, bin_index_o);
        mismatches++;
      end
      if (bin_value_o !== exp_beat.val) begin
        $display("%0t: bin_value (bin %0d) expected %0d actual %0d", $time, exp_beat.idx,
                 exp_beat.val, bin_value_o);
        mismatches++;
      end
      if (bin_saturated_o !== exp_beat.sat) begin
        $display("%0t: bin_saturated (bin %0d) expected %0b actual %0b", $time,
                 exp_beat.idx, exp_beat.sat, bin_saturated_o);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BINS; i++) begin
        bin_sums[i]  = '0;
        bin_marks[i] = 1'b0;
      end
      read_results_due.delete();
    end else begin
      if (done_o) compare_read_beat();
      if (start && !busy) update_bins();
    end
    pending_o    <= read_results_due.size();
    fail_count_o <= mismatches;
  end

endmodule

### tb/tb_count_sketch_accumulator_core.sv
// Testbench top for count_sketch_accumulator_core: drives directed, extreme-sample
// and random request beats and gives the verdict. Depends on csa_pkg and csa_checker.
module tb_count_sketch_accumulator_core;
  import csa_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_ITEMS = 580;
  localparam int          SAT_STEPS    = 32;
  localparam logic [31:0] SAMPLE_MIN   = 32'h8000_0000;
  localparam logic [31:0] SAMPLE_MAX   = 32'h7fff_ffff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     start          = 1'b0;
  logic                     busy;
  logic                     req_type_i     = REQ_ACC;
  logic [LABEL_W-1:0]       bin_label_i    = '0;
  logic                     keep_sign_i    = 1'b0;
  logic signed [31:0]       sample_value_i = '0;
  logic                     done_o;
  logic [LABEL_W-1:0]       bin_index_o;
  logic signed [47:0]       bin_value_o;
  logic                     bin_saturated_o;

  int fail_count;
  int pending_reads;
  int cycle_count = 0;
  bit gaps_on     = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  count_sketch_accumulator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .bin_label_i    (bin_label_i),
    .keep_sign_i    (keep_sign_i),
    .sample_value_i (sample_value_i),
    .done_o         (done_o),
    .bin_index_o    (bin_index_o),
    .bin_value_o    (bin_value_o),
    .bin_saturated_o(bin_saturated_o)
  );

  csa_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .bin_label_i    (bin_label_i),
    .keep_sign_i    (keep_sign_i),
    .sample_value_i (sample_value_i),
    .done_o         (done_o),
    .bin_index_o    (bin_index_o),
    .bin_value_o    (bin_value_o),
    .bin_saturated_o(bin_saturated_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_reads)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_count_sketch_accumulator_core failed");
      $finish;
    end
  end

  // one request beat; start stays high on return so beats can go back to back
  task automatic send_request(req_e req, logic [LABEL_W-1:0] label, logic keep,
                              logic [31:0] sample);
    if (gaps_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= req;
    bin_label_i    <= label;
    keep_sign_i    <= keep;
    sample_value_i <= sample;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_reads();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_reads != 0);
  endtask

  initial begin
    req_e        req;
    logic [9:0]  label;
    logic [31:0] sample;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: unwritten bin, extremes, negated minimum, forwarding hits
    send_request(REQ_READ, 10'd0,    1'b1, 32'hffff_ffff);
    send_request(REQ_ACC,  10'd0,    1'b1, SAMPLE_MAX);
    send_request(REQ_ACC,  10'd0,    1'b0, SAMPLE_MAX);
    send_request(REQ_ACC,  10'd0,    1'b0, SAMPLE_MIN);
    send_request(REQ_READ, 10'd0,    1'b0, 32'h0);
    send_request(REQ_READ, 10'd0,    1'b1, 32'h0);
    send_request(REQ_ACC,  10'd1023, 1'b1, 32'hffff_ffff);
    send_request(REQ_ACC,  10'd1023, 1'b1, 32'h0);
    send_request(REQ_ACC,  10'd1023, 1'b0, SAMPLE_MIN);
    send_request(REQ_READ, 10'd1023, 1'b0, SAMPLE_MAX);
    send_request(REQ_ACC,  10'd512,  1'b0, 32'h1);
    send_request(REQ_READ, 10'd512,  1'b1, 32'h0);
    send_request(REQ_ACC,  10'd512,  1'b1, 32'h5);
    send_request(REQ_READ, 10'd512,  1'b0, 32'h0);
    send_request(REQ_ACC,  10'd341,  1'b1, 32'h5555_5555);
    send_request(REQ_ACC,  10'd682,  1'b0, 32'haaaa_aaaa);
    send_request(REQ_READ, 10'd341,  1'b1, 32'h0);
    send_request(REQ_READ, 10'd682,  1'b0, 32'h0);

    // runs of extreme samples: bins 1 and 3 grow upwards, bin 2 downwards
    for (int i = 0; i < SAT_STEPS; i++) begin
      if (i == SAT_STEPS - 1) send_request(REQ_ACC, 10'd1, 1'b1, SAMPLE_MAX);
      else send_request(REQ_ACC, 10'd1, 1'b0, SAMPLE_MIN);
      send_request(REQ_ACC, 10'd2, 1'b1, SAMPLE_MIN);
      send_request(REQ_ACC, 10'd3, 1'b0, SAMPLE_MIN);
    end
    send_request(REQ_READ, 10'd1, 1'b0, 32'h0);
    send_request(REQ_ACC,  10'd2, 1'b1, 32'hffff_ffff);
    send_request(REQ_ACC,  10'd2, 1'b1, 32'h5);
    send_request(REQ_READ, 10'd2, 1'b0, 32'h0);
    send_request(REQ_READ, 10'd3, 1'b0, 32'h0);
    send_request(REQ_READ, 10'd3, 1'b0, 32'h0);

    // random mix, labels often on a few hot bins
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 200 && n < 400);
      if (n == 500) drain_reads();
      req   = ($urandom_range(99) < 30) ? REQ_READ : REQ_ACC;
      label = ($urandom_range(1)) ? 10'($urandom_range(7)) : 10'($urandom_range(1023));
      case ($urandom_range(19))
        0:       sample = SAMPLE_MIN;
        1:       sample = SAMPLE_MAX;
        2:       sample = 32'h0;
        3:       sample = 32'hffff_ffff;
        default: sample = $urandom;
      endcase
      send_request(req, label, 1'($urandom_range(1)), sample);
    end

    drain_reads();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("tb_count_sketch_accumulator_core passed");
    end else begin
      $display("tb_count_sketch_accumulator_core failed");
    end
    $finish;
  end

endmodule
